### rtl/cmq_pkg.sv
`default_nettype none

package cmq_pkg;

  localparam int QUAT_FRAC_BITS  = 14;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int IN_W            = 16;
  localparam int OUT_W           = 15;
  localparam int CORDIC_STEPS    = 23;
  localparam int ATAN_W          = 22;

  // 1/sqrt(2) in Q30
  localparam logic [29:0] INV_SQRT2_Q30 = 30'd759250125;

  typedef struct packed {
    logic signed [IN_W-1:0] first_x;
    logic signed [IN_W-1:0] first_y;
    logic signed [IN_W-1:0] first_z;
    logic signed [IN_W-1:0] first_w;
    logic signed [IN_W-1:0] second_x;
    logic signed [IN_W-1:0] second_y;
    logic signed [IN_W-1:0] second_z;
    logic signed [IN_W-1:0] second_w;
  } quat_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] angle_degrees;
    logic [OUT_W-1:0] axis_smallest;
    logic [OUT_W-1:0] axis_second;
    logic [OUT_W-1:0] axis_third;
  } result_item_t;

  // arctangent of 2^-step in degrees, 16 fraction bits
  function automatic logic [ATAN_W-1:0] atan_deg(input int step);
    logic [ATAN_W-1:0] v;
    case (step)
      0:       v = 22'd2949120;
      1:       v = 22'd1740967;
      2:       v = 22'd919879;
      3:       v = 22'd466945;
      4:       v = 22'd234379;
      5:       v = 22'd117304;
      6:       v = 22'd58666;
      7:       v = 22'd29335;
      8:       v = 22'd14668;
      9:       v = 22'd7334;
      10:      v = 22'd3667;
      11:      v = 22'd1833;
      12:      v = 22'd917;
      13:      v = 22'd458;
      14:      v = 22'd229;
      15:      v = 22'd115;
      16:      v = 22'd57;
      17:      v = 22'd29;
      18:      v = 22'd14;
      19:      v = 22'd7;
      20:      v = 22'd4;
      21:      v = 22'd2;
      22:      v = 22'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/cubic_misorientation_quat.sv
`default_nettype none

// Cubic misorientation of two Q2.14 unit quaternions: returns the angle in degrees
// (7 fraction bits, 0 to 180) and the axis from the three smallest sorted components
// of the relative quaternion, each divided by the sine of the half angle and saturated
// at 1.0; a zero angle gives axis (0,0,1). Fully pipelined: one item per cycle while the skid
// is empty. The depth is set by the 31-stage square root (one root bit per stage) followed
// by the 23-stage CORDIC, with the three restoring dividers running beside the CORDIC. A
// two-deep output (result register plus skid) lets the block take one more item after the
// output stalls.
module cubic_misorientation_quat (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     quat_valid,
  output logic                    quat_stall,
  input  cmq_pkg::quat_item_t     quat,
  output logic                    result_valid,
  input  wire                     result_stall,
  output cmq_pkg::result_item_t   result
);

  localparam int QF       = cmq_pkg::QUAT_FRAC_BITS;
  localparam int OUT_W    = cmq_pkg::OUT_W;
  localparam int PROD_W   = 2 * cmq_pkg::IN_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int MAG_W    = SUM_W - 1;
  localparam int MIX_W    = MAG_W + 1;
  localparam int ALL_W    = MAG_W + 2;
  localparam int MUL_W    = MIX_W + 30;
  localparam int C_W      = MAG_W + 1;
  localparam int PBITS    = 2 * QF;
  localparam int C_RSH    = (PBITS > 30) ? PBITS - 30 : 0;
  localparam int C_LSH    = (PBITS > 30) ? 0 : 30 - PBITS;
  localparam int CWIDE_W  = C_W + 1 + C_LSH;
  localparam int ROOT_TOP = 60;
  localparam int D_W      = ROOT_TOP + 1;
  localparam int SQ_W     = ROOT_TOP + 2;
  localparam int SQ_STEPS = ROOT_TOP / 2 + 1;
  localparam int S_W      = 31;
  localparam int CX_W     = 33;
  localparam int Z_W      = 25;
  localparam int NUM_SH   = 30 - QF;
  localparam int N_W      = MAG_W + NUM_SH + 1;
  localparam int STEPS    = cmq_pkg::CORDIC_STEPS;
  localparam int ANG_RSH  = 16 - cmq_pkg::ANGLE_FRAC_BITS;
  localparam int ZMAX     = 90 * 65536;
  localparam int ANG_MAX  = 180 * (1 << cmq_pkg::ANGLE_FRAC_BITS);

  localparam logic [C_W:0]       C_RND   = (C_RSH > 0) ? ((C_W+1)'(1) << (C_RSH - 1)) : '0;
  localparam logic [MUL_W-1:0]   M_RND   = MUL_W'(1) << 29;
  localparam logic [Z_W:0]       ANG_RND = (ANG_RSH > 0) ? ((Z_W+1)'(1) << (ANG_RSH - 1)) : '0;
  localparam logic [OUT_W-1:0]   ONE     = OUT_W'(1) << QF;
  localparam logic [D_W-1:0]     D_ONE   = D_W'(1) << ROOT_TOP;

  typedef struct packed {
    logic [SQ_W-1:0]            rem;
    logic [SQ_W-1:0]            res;
    logic [29:0]                c30;
    logic                       zero;
    logic [2:0][MAG_W-1:0]      lo;
  } sq_t;

  typedef struct packed {
    logic signed [CX_W-1:0]     x;
    logic signed [CX_W-1:0]     y;
    logic signed [Z_W-1:0]      z;
    logic [S_W-1:0]             s30;
    logic                       zero;
    logic [2:0]                 lo_zero;
    logic [2:0]                 sat;
    logic [2:0][N_W-1:0]        rem;
    logic [2:0][OUT_W-1:0]      q;
  } cd_t;

  // whole pipeline moves together; it holds only while the skid is occupied
  logic en;
  logic skid_valid;
  cmq_pkg::result_item_t skid;

  assign en         = !skid_valid;
  assign quat_stall = skid_valid;

  // stage 1: the sixteen component products
  logic signed [cmq_pkg::IN_W-1:0] q1 [4];
  logic signed [cmq_pkg::IN_W-1:0] q2 [4];
  assign q1[0] = quat.first_x;
  assign q1[1] = quat.first_y;
  assign q1[2] = quat.first_z;
  assign q1[3] = quat.first_w;
  assign q2[0] = quat.second_x;
  assign q2[1] = quat.second_y;
  assign q2[2] = quat.second_z;
  assign q2[3] = quat.second_w;

  logic v1;
  logic signed [PROD_W-1:0] p1 [4][4];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          p1[i][j] <= q1[i] * q2[j];
        end
      end
    end
  end

  // stage 2: relative quaternion and magnitudes
  logic signed [SUM_W-1:0] r [4];
  logic v2;
  logic [MAG_W-1:0] a2 [4];

  always_comb begin
    r[0] = -p1[0][3] + p1[3][0] - p1[1][2] + p1[2][1];
    r[1] = -p1[1][3] + p1[3][1] - p1[2][0] + p1[0][2];
    r[2] = -p1[2][3] + p1[3][2] - p1[0][1] + p1[1][0];
    r[3] = -p1[3][3] - p1[0][0] - p1[1][1] - p1[2][2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        a2[i] <= r[i][SUM_W-1] ? MAG_W'(-r[i]) : MAG_W'(r[i]);
      end
    end
  end

  // stage 3: four-input sorting network, ascending
  logic [MAG_W-1:0] l1 [4];
  logic [MAG_W-1:0] l2 [4];
  logic v3;
  logic [MAG_W-1:0] a3 [4];

  always_comb begin
    l1[0] = (a2[0] > a2[1]) ? a2[1] : a2[0];
    l1[1] = (a2[0] > a2[1]) ? a2[0] : a2[1];
    l1[2] = (a2[2] > a2[3]) ? a2[3] : a2[2];
    l1[3] = (a2[2] > a2[3]) ? a2[2] : a2[3];
    l2[0] = (l1[0] > l1[2]) ? l1[2] : l1[0];
    l2[2] = (l1[0] > l1[2]) ? l1[0] : l1[2];
    l2[1] = (l1[1] > l1[3]) ? l1[3] : l1[1];
    l2[3] = (l1[1] > l1[3]) ? l1[1] : l1[3];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a3[0] <= l2[0];
      a3[1] <= (l2[1] > l2[2]) ? l2[2] : l2[1];
      a3[2] <= (l2[1] > l2[2]) ? l2[1] : l2[2];
      a3[3] <= l2[3];
    end
  end

  // stage 4: sum of the two largest and of all four
  logic v4;
  logic [MIX_W-1:0] mix4;
  logic [ALL_W-1:0] all4;
  logic [MAG_W-1:0] top4;
  logic [2:0][MAG_W-1:0] lo4;

  always_ff @(posedge clk) begin
    if (en) begin
      mix4 <= MIX_W'(a3[2]) + MIX_W'(a3[3]);
      all4 <= ALL_W'(a3[0]) + ALL_W'(a3[1]) + ALL_W'(a3[2]) + ALL_W'(a3[3]);
      top4 <= a3[3];
      lo4  <= {a3[2], a3[1], a3[0]};
    end
  end

  // stage 5: scale by 1/sqrt 2, round the half sum
  logic v5;
  logic [MUL_W-1:0] prod5;
  logic [C_W-1:0] half5;
  logic [MAG_W-1:0] top5;
  logic [2:0][MAG_W-1:0] lo5;
  logic [ALL_W:0] all_rnd;

  assign all_rnd = (ALL_W+1)'(all4) + (ALL_W+1)'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      prod5 <= MUL_W'(mix4) * MUL_W'(cmq_pkg::INV_SQRT2_Q30);
      half5 <= C_W'(all_rnd >> 1);
      top5  <= top4;
      lo5   <= lo4;
    end
  end

  // stage 6: cosine as the largest candidate, moved to Q30
  logic [C_W-1:0] m6;
  logic [C_W-1:0] c6;
  logic [C_W:0] c_rnd;
  logic [CWIDE_W-1:0] c_wide;
  logic v6;
  logic [29:0] c30_6;
  logic zero6;
  logic [2:0][MAG_W-1:0] lo6;

  always_comb begin
    m6 = C_W'((prod5 + M_RND) >> 30);
    c6 = C_W'(top5);
    if (m6 > c6) begin
      c6 = m6;
    end
    if (half5 > c6) begin
      c6 = half5;
    end
    c_rnd  = (C_W+1)'(c6) + C_RND;
    c_wide = CWIDE_W'(c_rnd >> C_RSH) << C_LSH;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c30_6 <= c_wide[29:0];
      zero6 <= |c_wide[CWIDE_W-1:30];
      lo6   <= lo5;
    end
  end

  // stage 7: square of the cosine
  logic v7;
  logic [2*30-1:0] sq7;
  logic [29:0] c30_7;
  logic zero7;
  logic [2:0][MAG_W-1:0] lo7;

  always_ff @(posedge clk) begin
    if (en) begin
      sq7   <= c30_6 * c30_6;
      c30_7 <= c30_6;
      zero7 <= zero6;
      lo7   <= lo6;
    end
  end

  // stage 8 feeds the root pipeline with 1 - c*c
  logic sq_v [SQ_STEPS+1];
  sq_t sq_pipe [SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_pipe[0].rem  <= SQ_W'(D_ONE - D_W'(sq7));
      sq_pipe[0].res  <= '0;
      sq_pipe[0].c30  <= c30_7;
      sq_pipe[0].zero <= zero7;
      sq_pipe[0].lo   <= lo7;
    end
  end

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      sq_v[0] <= 1'b0;
    end else if (en) begin
      v1 <= quat_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      sq_v[0] <= v7;
    end
  end

  // integer square root, one root bit per stage
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (ROOT_TOP - 2 * k);
    sq_t nxt;
    logic [SQ_W-1:0] trial;

    always_comb begin
      nxt   = sq_pipe[k];
      trial = sq_pipe[k].res + BIT;
      if (sq_pipe[k].rem >= trial) begin
        nxt.rem = sq_pipe[k].rem - trial;
        nxt.res = (sq_pipe[k].res >> 1) + BIT;
      end else begin
        nxt.res = sq_pipe[k].res >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (en) begin
        sq_v[k+1] <= sq_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_pipe[k+1] <= nxt;
      end
    end
  end

  // cordic start: vector (cos, sin); the divider lanes start from the small components
  cd_t cd_head;
  logic [S_W-1:0] s30;

  assign s30 = sq_pipe[SQ_STEPS].res[S_W-1:0];

  always_comb begin
    cd_head.x    = CX_W'(sq_pipe[SQ_STEPS].c30);
    cd_head.y    = CX_W'(s30);
    cd_head.z    = '0;
    cd_head.s30  = s30;
    cd_head.zero = sq_pipe[SQ_STEPS].zero;
    cd_head.sat  = '0;
    cd_head.q    = '0;
    for (int i = 0; i < 3; i++) begin
      cd_head.lo_zero[i] = (sq_pipe[SQ_STEPS].lo[i] == '0);
      cd_head.rem[i]     = N_W'(sq_pipe[SQ_STEPS].lo[i]);
    end
  end

  logic cd_v [1:STEPS];
  cd_t cd_pipe [1:STEPS];

  // cordic vectoring, one rotation per stage; dividers: numerator, overflow check,
  // then one quotient bit per stage
  for (genvar k = 0; k < STEPS; k++) begin : g_cordic
    localparam logic signed [Z_W-1:0] ATAN = Z_W'(cmq_pkg::atan_deg(k));
    localparam bit QBIT_STEP = (k >= 2) && (k <= OUT_W + 1);
    localparam int QB = QBIT_STEP ? OUT_W + 1 - k : 0;
    cd_t src;
    cd_t nxt;
    logic src_v;
    logic signed [CX_W-1:0] dx;
    logic signed [CX_W-1:0] dy;
    logic [N_W-1:0] trial;

    if (k == 0) begin : g_first
      assign src   = cd_head;
      assign src_v = sq_v[SQ_STEPS];
    end else begin : g_next
      assign src   = cd_pipe[k];
      assign src_v = cd_v[k];
    end

    always_comb begin
      nxt = src;
      dx  = src.y >>> k;
      dy  = src.x >>> k;
      if (!src.y[CX_W-1]) begin
        nxt.x = src.x + dx;
        nxt.y = src.y - dy;
        nxt.z = src.z + ATAN;
      end else begin
        nxt.x = src.x - dx;
        nxt.y = src.y + dy;
        nxt.z = src.z - ATAN;
      end
      trial = N_W'(src.s30) << QB;
      for (int i = 0; i < 3; i++) begin
        if (k == 0) begin
          nxt.rem[i] = (src.rem[i] << NUM_SH) + N_W'(src.s30 >> 1);
        end else if (k == 1) begin
          nxt.sat[i] = (src.rem[i] >= (N_W'(src.s30) << OUT_W));
        end else if (QBIT_STEP) begin
          if (src.rem[i] >= trial) begin
            nxt.rem[i]   = src.rem[i] - trial;
            nxt.q[i][QB] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cd_v[k+1] <= 1'b0;
      end else if (en) begin
        cd_v[k+1] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cd_pipe[k+1] <= nxt;
      end
    end
  end

  // final stage: clamp, round the angle, saturate the axis, zero-angle override
  function automatic logic [OUT_W-1:0] axis_pick(input logic lo_zero, input logic sat,
                                                 input logic [OUT_W-1:0] q);
    logic [OUT_W-1:0] v;
    if (lo_zero) begin
      v = '0;
    end else if (sat || (q > ONE)) begin
      v = ONE;
    end else begin
      v = q;
    end
    return v;
  endfunction

  cd_t cd_last;
  logic [Z_W-2:0] zc;
  logic [Z_W:0] ang;
  cmq_pkg::result_item_t fin_next;
  logic fin_valid;
  cmq_pkg::result_item_t fin;

  assign cd_last = cd_pipe[STEPS];

  always_comb begin
    if (cd_last.z[Z_W-1]) begin
      zc = '0;
    end else if (cd_last.z > Z_W'(ZMAX)) begin
      zc = (Z_W-1)'(ZMAX);
    end else begin
      zc = cd_last.z[Z_W-2:0];
    end
    ang = ((Z_W+1)'({zc, 1'b0}) + ANG_RND) >> ANG_RSH;
    if (cd_last.zero) begin
      fin_next.angle_degrees = '0;
      fin_next.axis_smallest = '0;
      fin_next.axis_second   = '0;
      fin_next.axis_third    = ONE;
    end else begin
      fin_next.angle_degrees = ang[OUT_W-1:0];
      fin_next.axis_smallest = axis_pick(cd_last.lo_zero[0], cd_last.sat[0], cd_last.q[0]);
      fin_next.axis_second   = axis_pick(cd_last.lo_zero[1], cd_last.sat[1], cd_last.q[1]);
      fin_next.axis_third    = axis_pick(cd_last.lo_zero[2], cd_last.sat[2], cd_last.q[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (en) begin
      fin_valid <= cd_v[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin <= fin_next;
    end
  end

  // result register with a skid behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (en) begin
      if (!result_valid || !result_stall) begin
        result_valid <= fin_valid;
      end else begin
        skid_valid <= fin_valid;
      end
    end else if (!result_stall) begin
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!result_valid || !result_stall) begin
        result <= fin;
      end else begin
        skid <= fin;
      end
    end else if (!result_stall) begin
      result <= skid;
    end
  end

  // checks
  a_skid_behind_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid holds an item while the result register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(result_valid && result_stall))
    else $error("skid filled while the result was not stalled");

  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.axis_smallest <= ONE) && (result.axis_second <= ONE)
                     && (result.axis_third <= ONE))
    else $error("axis value above one");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.angle_degrees <= OUT_W'(ANG_MAX)))
    else $error("angle above 180 degrees");

endmodule

`default_nettype wire

### bench/cubic_misorientation_quat_check.sv
`default_nettype none

module cubic_misorientation_quat_check (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    quat_valid,
  input  wire                    quat_stall,
  input  cmq_pkg::quat_item_t    quat,
  input  wire                    result_valid,
  input  wire                    result_stall,
  input  cmq_pkg::result_item_t  result,
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ATAN_TABLE [cmq_pkg::CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
  };

  cmq_pkg::result_item_t misorientation_q[$];

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [cmq_pkg::OUT_W-1:0] axis_of(longint unsigned a,
                                                        longint unsigned s);
    longint unsigned one, q;
    one = 64'd1 << cmq_pkg::QUAT_FRAC_BITS;
    if (a == 0) return '0;
    if (s == 0) return one[cmq_pkg::OUT_W-1:0];
    q = ((a << (30 - cmq_pkg::QUAT_FRAC_BITS)) + (s >> 1)) / s;
    if (q > one) q = one;
    return q[cmq_pkg::OUT_W-1:0];
  endfunction

  function automatic cmq_pkg::result_item_t misorientation(cmq_pkg::quat_item_t q);
    longint x1, y1, z1, w1, x2, y2, z2, w2, cx, cy, z, dx, dy, tw;
    longint r [4];
    longint unsigned a [4], t, c, m, c30, s30, ang;
    cmq_pkg::result_item_t res;
    x1 = q.first_x; y1 = q.first_y; z1 = q.first_z; w1 = q.first_w;
    x2 = q.second_x; y2 = q.second_y; z2 = q.second_z; w2 = q.second_w;
    r[0] = -x1 * w2 + w1 * x2 - y1 * z2 + z1 * y2;
    r[1] = -y1 * w2 + w1 * y2 - z1 * x2 + x1 * z2;
    r[2] = -z1 * w2 + w1 * z2 - x1 * y2 + y1 * x2;
    r[3] = -w1 * w2 - x1 * x2 - y1 * y2 - z1 * z2;
    for (int i = 0; i < 4; i++) a[i] = r[i] < 0 ? -r[i] : r[i];
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3 - i; j++)
        if (a[j] > a[j+1]) begin
          t = a[j]; a[j] = a[j+1]; a[j+1] = t;
        end
    c = a[3];
    m = ((a[2] + a[3]) * 64'd759250125 + (64'd1 << 29)) >> 30;
    if (m > c) c = m;
    m = (a[0] + a[1] + a[2] + a[3] + 1) >> 1;
    if (m > c) c = m;
    c30 = c << (30 - 2 * cmq_pkg::QUAT_FRAC_BITS);
    if (c30 >= (64'd1 << 30)) begin
      res = '0;
      res.axis_third = cmq_pkg::OUT_W'(1 << cmq_pkg::QUAT_FRAC_BITS);
      return res;
    end
    s30 = root64((64'd1 << 60) - c30 * c30);
    cx = c30; cy = s30; z = 0;
    for (int i = 0; i < cmq_pkg::CORDIC_STEPS; i++) begin
      dx = floor_shift(cy, i);
      dy = floor_shift(cx, i);
      if (cy >= 0) begin
        cx += dx; cy -= dy; z += ATAN_TABLE[i];
      end else begin
        cx -= dx; cy += dy; z -= ATAN_TABLE[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 90 * 65536) z = 90 * 65536;
    tw = 2 * z;
    ang = (tw + (64'd1 << (15 - cmq_pkg::ANGLE_FRAC_BITS))) >> (16 - cmq_pkg::ANGLE_FRAC_BITS);
    res.angle_degrees = ang[cmq_pkg::OUT_W-1:0];
    res.axis_smallest = axis_of(a[0], s30);
    res.axis_second = axis_of(a[1], s30);
    res.axis_third = axis_of(a[2], s30);
    return res;
  endfunction

  assign pending = misorientation_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    cmq_pkg::result_item_t want;
    if (!rst && quat_valid && !quat_stall) misorientation_q.push_back(misorientation(quat));
    if (!rst && result_valid && !result_stall) begin
      if (misorientation_q.size() == 0) begin
        $error("result with no item waiting");
        fail_count++;
      end else begin
        want = misorientation_q.pop_front();
        if (result.angle_degrees !== want.angle_degrees) begin
          $error("angle_degrees exp %0d got %0d", want.angle_degrees, result.angle_degrees);
          fail_count++;
        end
        if (result.axis_smallest !== want.axis_smallest) begin
          $error("axis_smallest exp %0d got %0d", want.axis_smallest, result.axis_smallest);
          fail_count++;
        end
        if (result.axis_second !== want.axis_second) begin
          $error("axis_second exp %0d got %0d", want.axis_second, result.axis_second);
          fail_count++;
        end
        if (result.axis_third !== want.axis_third) begin
          $error("axis_third exp %0d got %0d", want.axis_third, result.axis_third);
          fail_count++;
        end
      end
    end
  end

endmodule

`default_nettype wire

### bench/cubic_misorientation_quat_test.sv
`default_nettype none

module cubic_misorientation_quat_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic quat_valid = 1'b0;
  logic result_stall = 1'b0;
  logic quat_stall, result_valid;
  cmq_pkg::quat_item_t quat = '0;
  cmq_pkg::result_item_t result;
  int fail_count, pending;
  bit sending = 1'b1;

  always #5 clk = ~clk;

  cubic_misorientation_quat uut (
    .clk(clk), .rst(rst),
    .quat_valid(quat_valid), .quat_stall(quat_stall), .quat(quat),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  cubic_misorientation_quat_check check (
    .clk(clk), .rst(rst),
    .quat_valid(quat_valid), .quat_stall(quat_stall), .quat(quat),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .fail_count(fail_count), .pending(pending)
  );

  // a random component; mostly in the unit range, sometimes any 16-bit pattern
  function automatic logic [15:0] rand_comp();
    if ($urandom_range(0, 19) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // random unit quaternion: normalize a random 4-vector in real math
  function automatic logic [63:0] rand_unit();
    real v [4], n;
    logic [63:0] q;
    n = 0.0;
    for (int i = 0; i < 4; i++) begin
      v[i] = $itor($signed($urandom_range(0, 2000)) - 1000);
      n += v[i] * v[i];
    end
    if (n == 0.0) return {16'sd0, 16'sd0, 16'sd0, 16'sd16384};
    n = $sqrt(n);
    for (int i = 0; i < 4; i++) q[63-16*i -: 16] = 16'($rtoi(v[i] / n * 16384.0));
    return q;
  endfunction

  // hold the item until accepted, then, if gaps is set, wait a random gap
  task automatic send_item(cmq_pkg::quat_item_t it, bit gaps);
    int gap;
    quat <= it;
    quat_valid <= 1'b1;
    @(posedge clk);
    while (quat_stall) @(posedge clk);
    gap = gaps ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      quat_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // after each result the receiver may stall for a random hold
  always @(posedge clk) begin
    int hold;
    if (result_valid && !result_stall) begin
      hold = $urandom_range(0, 19);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    cmq_pkg::quat_item_t it;
    logic [15:0] corner [5] = '{16'sd16384, -16'sd16384, 16'sd0, 16'h7fff, 16'h8000};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity pair gives zero angle, a sign flip is still zero angle
    it = {16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384};
    send_item(it, 0);
    it.second_w = -16'sd16384;
    send_item(it, 0);
    // all-zero item gives 180 degrees
    send_item('0, 0);
    // 90 degrees about z, then a pair of orthogonal quaternions
    it = {16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd11585, 16'sd11585};
    send_item(it, 0);
    it = {16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384};
    send_item(it, 0);
    // field extremes, including patterns outside the unit range
    for (int i = 0; i < 5; i++) begin
      for (int k = 0; k < 8; k++) it[127-16*k -: 16] = corner[(i + k) % 5];
      send_item(it, 0);
    end
    send_item({8{16'h7fff}}, 0);
    send_item({8{16'h8000}}, 0);
    send_item({8{16'hffff}}, 0);
    // small angle: second slightly off the first, where the sine nearly vanishes
    it = {16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd1, 16'sd0, 16'sd0, 16'sd16384};
    send_item(it, 0);
    it = {16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd2, 16'sd16383};
    send_item(it, 0);

    // random items with random gaps; one stretch with none
    for (int n = 0; n < 1350; n++) begin
      if (n % 3 != 0) it = {rand_unit(), rand_unit()};
      else for (int k = 0; k < 8; k++) it[127-16*k -: 16] = rand_comp();
      send_item(it, !(n >= 300 && n < 500));
      // sender pauses until the pipeline has drained
      if (n == 700) begin
        quat_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
    end
    quat_valid <= 1'b0;
    sending = 1'b0;
  end

  initial begin
    wait (!sending);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("** cubic_misorientation_quat: PASSED **");
    end else begin
      $display("** cubic_misorientation_quat: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("** cubic_misorientation_quat: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
